// File: src/ott_pkg.sv
`timescale 1ns / 1ps
package ott_pkg;

  typedef enum logic [2:0] {
    FN_ISSUE  = 3'd0,
    FN_SEND   = 3'd1,
    FN_RESP   = 3'd2,
    FN_TICK   = 3'd3,
    FN_REPLY  = 3'd4,
    FN_CANCEL = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    K_ISSUED  = 3'd0,
    K_FULL    = 3'd1,
    K_SENT    = 3'd2,
    K_OK      = 3'd3,
    K_DROP    = 3'd4,
    K_TIMEOUT = 3'd5,
    K_REPLY   = 3'd6,
    K_DONE    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SENDING = 2'd1,
    ST_WAITING = 2'd2
  } slot_st_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_SCAN,
    C_SINGLE,
    C_EMIT,
    C_DONE
  } ctl_e;

  localparam logic [7:0] ADDR_ACTIVE  = 8'd0;
  localparam logic [7:0] ADDR_DEFAULT = 8'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  peer;
    logic [7:0]  slot_index;
    logic [7:0]  seq_number;
    logic [31:0] timeout_len;
    logic        use_default;
    logic        send_ok;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [3:0]  slot;
    logic [7:0]  seq_out;
    logic [7:0]  peer_out;
    logic [31:0] dropped_total;
    logic [31:0] timeout_total;
    logic        last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic single;   // do single-result operation
    logic scan;     // process slot at scan pointer
    logic adv;      // advance scan pointer
    logic emit;     // put pending result into output register
    logic emit_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_scan;  // operation is cancel, or tick before shutdown
    logic scan_end; // pointer past active slots
    logic hit;      // scanned slot yields a result
    logic out_busy; // output register full and not leaving
  } sts_t;

endpackage

// File: src/ott_ctrl.sv
`timescale 1ns / 1ps
module ott_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ott_pkg::sts_t sts_i,
  output ott_pkg::cmd_t cmd_o
);
  import ott_pkg::*;

  ctl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= C_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE:   if (in_valid_i) state_d = C_SINGLE;
      C_SINGLE: state_d = sts_i.is_scan ? C_SCAN : C_EMIT;
      C_SCAN: begin
        if (sts_i.scan_end) state_d = C_DONE;
        else if (sts_i.hit) state_d = C_EMIT;
      end
      C_EMIT:   if (!sts_i.out_busy) state_d = sts_i.is_scan ? C_SCAN : C_IDLE;
      C_DONE:   if (!sts_i.out_busy) state_d = C_IDLE;
      default:  state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      C_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      C_SINGLE: cmd_o.single = 1'b1;
      C_SCAN: begin
        // a hit holds the pointer until its result is moved into the output register
        cmd_o.scan = !sts_i.scan_end;
        cmd_o.adv  = !sts_i.scan_end && !sts_i.hit;
      end
      C_EMIT: begin
        cmd_o.emit = !sts_i.out_busy;
        cmd_o.adv  = !sts_i.out_busy && sts_i.is_scan;
      end
      C_DONE: cmd_o.emit_done = !sts_i.out_busy;
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == C_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_busy) else $error("emit onto busy output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == C_SINGLE) else $error("load lost");
endmodule

// File: src/ott_dp.sv
`timescale 1ns / 1ps
module ott_dp #(
  parameter int SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ott_pkg::in_item_t in_data_i,
  input  ott_pkg::cmd_t     cmd_i,
  output ott_pkg::sts_t     sts_o,
  input  logic [4:0]        active_i,
  input  logic [31:0]       deflt_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ott_pkg::out_item_t out_data_o
);
  import ott_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  slot_st_e          st_q    [SLOTS];
  logic              armed_q [SLOTS];
  logic [7:0]        peer_q  [SLOTS];
  logic [7:0]        seq_q   [SLOTS];
  logic [31:0]       len_q   [SLOTS];
  logic [31:0]       dl_q    [SLOTS];

  in_item_t    it_q;
  logic [7:0]  ctr_q;
  logic        shut_q;
  logic [31:0] drop_q, tout_q;
  logic [CW-1:0] ptr_q;
  kind_e       pk_q;
  logic [3:0]  ps_q;
  logic [7:0]  pq_q, pp_q;
  logic        ov_q;
  out_item_t   od_q;

  logic [CW-1:0] n_act;
  assign n_act = (32'(active_i) < SLOTS) ? CW'(active_i) : CW'(SLOTS);

  // lowest idle slot below the active count
  logic          free_f;
  logic [IW-1:0] free_i;
  always_comb begin
    free_f = 1'b0;
    free_i = '0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (CW'(i) < n_act && st_q[i] == ST_IDLE) begin
        free_f = 1'b1;
        free_i = IW'(i);
      end
  end

  logic          idx_ok;
  logic [IW-1:0] ix;
  assign idx_ok = {24'd0, it_q.slot_index} < 32'(n_act);
  assign ix     = it_q.slot_index[IW-1:0];

  logic [IW-1:0] pi;
  logic          is_tick, hit;
  logic [31:0]   diff;
  assign pi      = ptr_q[IW-1:0];
  assign is_tick = it_q.func == FN_TICK;
  assign diff    = it_q.now_time - dl_q[pi];
  always_comb begin
    if (is_tick) hit = st_q[pi] == ST_WAITING && armed_q[pi] && !diff[31];
    else hit = st_q[pi] == ST_WAITING || st_q[pi] == ST_SENDING;
  end

  logic out_busy;
  assign out_busy = ov_q && out_stall_i;
  assign sts_o.is_scan  = (it_q.func == FN_CANCEL) || (is_tick && !shut_q);
  assign sts_o.scan_end = ptr_q >= n_act;
  assign sts_o.hit      = hit;
  assign sts_o.out_busy = out_busy;

  logic [31:0] arm_d;
  assign arm_d = it_q.now_time + len_q[pi];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= ST_IDLE;
        armed_q[i] <= 1'b0;
      end
      ctr_q <= '0; shut_q <= 1'b0; drop_q <= '0; tout_q <= '0;
      ptr_q <= '0; ov_q <= 1'b0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      if (cmd_i.load) ptr_q <= '0;
      if (cmd_i.single) begin
        pk_q <= K_DONE; ps_q <= '0; pq_q <= '0; pp_q <= '0;
        case (it_q.func)
          FN_ISSUE: begin
            if (free_f) begin
              st_q[free_i] <= ST_SENDING;
              peer_q[free_i] <= it_q.peer;
              seq_q[free_i] <= ctr_q;
              len_q[free_i] <= it_q.use_default ? deflt_i : it_q.timeout_len;
              armed_q[free_i] <= 1'b0;
              ctr_q <= ctr_q + 8'd1;
              pk_q <= K_ISSUED; ps_q <= 4'(free_i); pq_q <= ctr_q; pp_q <= it_q.peer;
            end else pk_q <= K_FULL;
          end
          FN_SEND: if (idx_ok && st_q[ix] == ST_SENDING) begin
            st_q[ix] <= it_q.send_ok ? ST_WAITING : ST_IDLE;
            pk_q <= K_SENT; ps_q <= it_q.slot_index[3:0];
          end
          FN_RESP: if (!shut_q && idx_ok) begin
            ps_q <= it_q.slot_index[3:0];
            if (st_q[ix] != ST_WAITING || peer_q[ix] != it_q.peer
                || seq_q[ix] != it_q.seq_number) begin
              drop_q <= drop_q + 32'd1;
              pk_q <= K_DROP;
            end else begin
              st_q[ix] <= ST_IDLE;
              pk_q <= K_OK; pq_q <= seq_q[ix]; pp_q <= peer_q[ix];
            end
          end
          FN_REPLY: begin
            pk_q <= K_REPLY; pq_q <= ctr_q; ctr_q <= ctr_q + 8'd1;
          end
          FN_CANCEL: shut_q <= 1'b1;
          default: ;
        endcase
      end
      if (cmd_i.scan) begin
        if (hit) begin
          st_q[pi] <= ST_IDLE;
          if (is_tick) tout_q <= tout_q + 32'd1;
          pk_q <= K_TIMEOUT; ps_q <= 4'(pi); pq_q <= seq_q[pi]; pp_q <= peer_q[pi];
        end else if (is_tick && st_q[pi] == ST_WAITING && !armed_q[pi]
                     && len_q[pi] != 32'd0) begin
          dl_q[pi] <= (arm_d == 32'd0) ? 32'd1 : arm_d;
          armed_q[pi] <= 1'b1;
        end
      end
      if (cmd_i.adv) ptr_q <= ptr_q + CW'(1);
      if (cmd_i.emit || cmd_i.emit_done) begin
        ov_q <= 1'b1;
        od_q.result_kind <= cmd_i.emit ? pk_q : K_DONE;
        od_q.slot <= cmd_i.emit ? ps_q : 4'd0;
        od_q.seq_out <= cmd_i.emit ? pq_q : 8'd0;
        od_q.peer_out <= cmd_i.emit ? pp_q : 8'd0;
        od_q.dropped_total <= drop_q;
        od_q.timeout_total <= tout_q;
        od_q.last <= cmd_i.emit_done || !sts_o.is_scan;
      end
    end
  end

  always_ff @(posedge clk_i) if (cmd_i.load) it_q <= in_data_i;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(od_q)) else $error("output changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> sts_o.is_scan) else $error("scan on single op");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_done |-> sts_o.scan_end) else $error("done before scan end");
endmodule

// File: src/outstanding_transaction_tracker.sv
`timescale 1ns / 1ps
// issue, send outcome, response, reply, unknown codes and ticks after a cancel give one result
// cancel and a pre-shutdown tick walk the active slots one per cycle, pausing to emit each hit
// one item at a time; the next transfer is taken once the last result is in the output register
// reset (rst_ni low, async) idles every slot, clears counters, shutdown and the output valid
// active_slots resets to 16 and default_timeout to 1000
module outstanding_transaction_tracker #(
  parameter int SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ott_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ott_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ott_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // configuration registers
  logic [4:0]  active_q;
  logic [31:0] deflt_q;
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 5'd16;
      deflt_q  <= 32'd1000;
    end else if (wr) begin
      if ({5'd0, paddr} == ADDR_ACTIVE) active_q <= pwdata[4:0];
      else if ({5'd0, paddr} == ADDR_DEFAULT) deflt_q <= pwdata;
    end
  end

  // read mux
  always_comb begin
    if ({5'd0, paddr} == ADDR_ACTIVE) prdata = {27'd0, active_q};
    else if ({5'd0, paddr} == ADDR_DEFAULT) prdata = deflt_q;
    else prdata = '0;
  end

  // sequencer: one slot per cycle during tick and cancel scans, pausing to emit each hit
  ott_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // slot table, counters and output register
  ott_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .active_i(active_q), .deflt_i(deflt_q),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second transfer taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= 5'd31) else $error("active count out of range");
endmodule

// File: tb/ott_result_checker.sv
`timescale 1ns / 1ps
module ott_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  ott_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ott_pkg::out_item_t out_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o,
  output int                 timeout_seen_o
);
  import ott_pkg::*;

  localparam int NSLOT = 16;

  // predictor copy of the table
  slot_st_e    st_q[NSLOT];
  logic [7:0]  peer_q[NSLOT];
  logic [7:0]  seqn_q[NSLOT];
  logic [31:0] len_q[NSLOT];
  logic [31:0] dl_q[NSLOT];
  logic        armed_q[NSLOT];
  logic [7:0]  seq_ctr;
  logic        shut;
  logic [31:0] drops, touts;
  logic [4:0]  act_reg;
  logic [31:0] def_reg;

  out_item_t expected_results[$];

  // totals as they stand when the result is produced
  function automatic out_item_t mk(kind_e k, int s, logic [7:0] sq, logic [7:0] pr);
    out_item_t r;
    r.result_kind = k;
    r.slot = s[3:0];
    r.seq_out = sq;
    r.peer_out = pr;
    r.dropped_total = drops;
    r.timeout_total = touts;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_transfer(input in_item_t it);
    out_item_t res[$];
    int n_act;
    int i;
    logic [31:0] d;
    n_act = (act_reg < NSLOT) ? act_reg : NSLOT;
    case (it.func)
      FN_ISSUE: begin
        for (i = 0; i < n_act; i++) if (st_q[i] == ST_IDLE) break;
        if (i >= n_act) res.push_back(mk(K_FULL, 0, 0, 0));
        else begin
          st_q[i] = ST_SENDING;
          peer_q[i] = it.peer;
          seqn_q[i] = seq_ctr;
          seq_ctr++;
          len_q[i] = it.use_default ? def_reg : it.timeout_len;
          dl_q[i] = 0;
          armed_q[i] = 0;
          res.push_back(mk(K_ISSUED, i, seqn_q[i], it.peer));
        end
      end
      FN_SEND: begin
        if (it.slot_index >= n_act || st_q[it.slot_index] != ST_SENDING)
          res.push_back(mk(K_DONE, 0, 0, 0));
        else begin
          st_q[it.slot_index] = it.send_ok ? ST_WAITING : ST_IDLE;
          res.push_back(mk(K_SENT, it.slot_index, 0, 0));
        end
      end
      FN_RESP: begin
        if (shut || it.slot_index >= n_act) res.push_back(mk(K_DONE, 0, 0, 0));
        else if (st_q[it.slot_index] != ST_WAITING || peer_q[it.slot_index] != it.peer
                 || seqn_q[it.slot_index] != it.seq_number) begin
          drops++;
          res.push_back(mk(K_DROP, it.slot_index, 0, 0));
        end else begin
          st_q[it.slot_index] = ST_IDLE;
          res.push_back(mk(K_OK, it.slot_index, seqn_q[it.slot_index],
                           peer_q[it.slot_index]));
        end
      end
      FN_TICK: begin
        if (!shut) begin
          for (i = 0; i < n_act; i++) begin
            if (st_q[i] != ST_WAITING) continue;
            if (!armed_q[i]) begin
              if (len_q[i] != 0) begin
                d = it.now_time + len_q[i];
                dl_q[i] = (d == 0) ? 32'd1 : d;
                armed_q[i] = 1;
              end
              continue;
            end
            d = it.now_time - dl_q[i];
            if (d[31]) continue;
            touts++;
            st_q[i] = ST_IDLE;
            res.push_back(mk(K_TIMEOUT, i, seqn_q[i], peer_q[i]));
          end
        end
        res.push_back(mk(K_DONE, 0, 0, 0));
      end
      FN_REPLY: begin
        res.push_back(mk(K_REPLY, 0, seq_ctr, 0));
        seq_ctr++;
      end
      FN_CANCEL: begin
        shut = 1;
        for (i = 0; i < n_act; i++)
          if (st_q[i] != ST_IDLE) begin
            st_q[i] = ST_IDLE;
            res.push_back(mk(K_TIMEOUT, i, seqn_q[i], peer_q[i]));
          end
        res.push_back(mk(K_DONE, 0, 0, 0));
      end
      default: res.push_back(mk(K_DONE, 0, 0, 0));
    endcase
    // the final result carries the totals after this input
    foreach (res[j]) begin
      if (j == res.size() - 1) begin
        res[j].dropped_total = drops;
        res[j].timeout_total = touts;
        res[j].last = 1'b1;
      end
      expected_results.push_back(res[j]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        st_q[i] = ST_IDLE;
        armed_q[i] = 0;
        peer_q[i] = 0;
        seqn_q[i] = 0;
        len_q[i] = 0;
        dl_q[i] = 0;
      end
      seq_ctr = 0;
      shut = 0;
      drops = 0;
      touts = 0;
      act_reg = 16;
      def_reg = 1000;
      expected_results.delete();
      fail_count_o = 0;
      result_count_o = 0;
      timeout_seen_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_ACTIVE[2:0]) act_reg = pwdata[4:0];
        else if (paddr == ADDR_DEFAULT[2:0]) def_reg = pwdata;
      end
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (out_data_i.result_kind == K_TIMEOUT) timeout_seen_o++;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result transfer: %p", out_data_i);
        end else begin
          e = expected_results.pop_front();
          if (out_data_i !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch\n  expected %p\n  actual   %p", e, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_transfer(in_data_i);
    end
    pending_o = expected_results.size();
  end
endmodule

// File: tb/tb_outstanding_transaction_tracker.sv
`timescale 1ns / 1ps
module tb_outstanding_transaction_tracker;
  import ott_pkg::*;

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_item_t out_data_o;
  logic      psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, result_count, timeout_seen;
  int transfers_sent;
  bit calm;  // stretch with no idling on either side

  // clock: 12 ns period
  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  outstanding_transaction_tracker u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ott_result_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .result_count_o(result_count), .timeout_seen_o(timeout_seen)
  );

  // receiver stalls at random with a chance of 19 in 100, never in calm stretches
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 19);
  end

  // tick clock of the tracked protocol, advanced by a random step before each random tick
  logic [31:0] ms_now = 32'd100;

  // one input transfer; random gap before unless calm, then hold until accepted
  // valid drops after the transfer, while the block is busy anyway
  task automatic send_item(input in_item_t it);
    if (!calm)
      while ($urandom_range(99) < 19) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
    transfers_sent++;
    @(posedge clk_i);
  endtask

  // register write: setup then access cycle
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  // wait for all expected results, then a scan's worth of quiet cycles
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic in_item_t blank(func_e f);
    in_item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  task automatic do_issue(input logic [7:0] pr, input logic [31:0] len, input bit dflt);
    in_item_t it;
    it = blank(FN_ISSUE);
    it.peer = pr;
    it.timeout_len = len;
    it.use_default = dflt;
    send_item(it);
  endtask

  task automatic do_send(input logic [7:0] idx, input bit ok);
    in_item_t it;
    it = blank(FN_SEND);
    it.slot_index = idx;
    it.send_ok = ok;
    send_item(it);
  endtask

  task automatic do_resp(input logic [7:0] idx, input logic [7:0] pr, input logic [7:0] sq);
    in_item_t it;
    it = blank(FN_RESP);
    it.slot_index = idx;
    it.peer = pr;
    it.seq_number = sq;
    send_item(it);
  endtask

  task automatic do_tick(input logic [31:0] t);
    in_item_t it;
    it = blank(FN_TICK);
    it.now_time = t;
    send_item(it);
  endtask

  // fully random fields, any func code but cancel, including the unused ones
  task automatic do_noise();
    in_item_t it;
    it = {$urandom, $urandom, $urandom};
    it.func = 3'($urandom_range(7));
    if (it.func == FN_CANCEL) it.func = FN_REPLY;
    // send half of the slot indices to slots 0 to 3, the rest stay random
    it.slot_index = $urandom_range(1) ? it.slot_index : 8'($urandom_range(3));
    send_item(it);
  endtask

  // base for the sequence number guesses of random responses, set once after the directed part
  logic [7:0] seq_mirror;
  logic [7:0] slot_peer_tb[16];
  logic [7:0] slot_seq_tb[16];
  bit         slot_used[16];

  initial begin
    int k, n, s;
    logic [7:0] pr;
    calm = 0;
    transfers_sent = 0;
    seq_mirror = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: small table and a wrapping deadline
    reg_write(ADDR_ACTIVE[2:0], 32'd2);
    reg_write(ADDR_DEFAULT[2:0], 32'd5);
    do_issue(8'hFF, 32'd0, 1'b1);        // slot 0, default length
    do_issue(8'h00, 32'hFFFF_FFFF, 1'b0); // slot 1, deadline wraps
    do_issue(8'h55, 32'd7, 1'b0);        // table full
    do_send(8'd0, 1'b1);
    do_send(8'd1, 1'b1);
    do_send(8'd0, 1'b1);                 // not sending any more
    do_send(8'd200, 1'b0);               // out of range
    do_resp(8'd0, 8'hFF, 8'd9);          // wrong sequence
    do_resp(8'd255, 8'hFF, 8'd0);        // out of range
    do_tick(32'hFFFF_FFFF);              // arms both
    do_tick(32'd3);                      // slot 0 deadline at 4, not yet; slot 1 times out
    do_tick(32'd4);                      // slot 0 times out
    do_resp(8'd1, 8'h00, 8'd1);          // response to slot 1, dropped after its timeout
    do_issue(8'h12, 32'd0, 1'b0);        // length zero never expires
    do_send(8'd0, 1'b0);                 // failed send frees slot
    begin
      in_item_t it;
      it = blank(FN_REPLY);
      send_item(it);
      it = '1;                           // unknown code, all ones
      send_item(it);
      it.func = 3'd6;
      send_item(it);
    end
    drain();
    reg_write(ADDR_ACTIVE[2:0], 32'd0);  // zero slots
    do_issue(8'h01, 32'd1, 1'b0);
    do_tick(32'd10);
    drain();
    reg_write(ADDR_ACTIVE[2:0], 32'd31); // above the table size
    reg_write(ADDR_DEFAULT[2:0], 32'hFFFF_FFFF);
    seq_mirror = 3;

    // random phases: well-formed lifecycles with noise mixed in
    for (int ph = 0; ph < 4; ph++) begin
      calm = (ph == 2);
      for (k = 0; k < 16; k++) slot_used[k] = 0;
      for (k = 0; k < 85; k++) begin
        n = $urandom_range(99);
        s = $urandom_range(15);
        if (n < 30) begin
          pr = 8'($urandom);
          do_issue(pr, (ph == 1) ? $urandom : $urandom_range(60), $urandom_range(3) == 0);
        end else if (n < 50) do_send(8'(s), $urandom_range(9) != 0);
        else if (n < 70) begin
          // correct or near-miss response using a guessed peer and sequence number
          do_resp(8'(s), $urandom_range(1) ? 8'($urandom) : 8'h00,
                  seq_mirror - 8'($urandom_range(4)));
        end else if (n < 88) begin
          ms_now += $urandom_range(40);
          do_tick(ms_now);
        end else do_noise();
      end
      drain();
      case (ph)
        0: begin
          reg_write(ADDR_ACTIVE[2:0], 32'd1);
          reg_write(ADDR_DEFAULT[2:0], 32'd0);
        end
        1: begin
          reg_write(ADDR_ACTIVE[2:0], 32'd16);
          reg_write(ADDR_DEFAULT[2:0], 32'd20);
        end
        default: reg_write(ADDR_ACTIVE[2:0], 32'd9);
      endcase
    end
    calm = 0;

    // cancel, then requests that are still allowed or ignored
    begin
      in_item_t it;
      do_issue(8'hA5, 32'd30, 1'b0);
      it = blank(FN_CANCEL);
      send_item(it);
      do_resp(8'd0, 8'hA5, 8'd0);
      do_tick(ms_now + 1000);
      do_issue(8'h5A, 32'd0, 1'b1);
      do_send(8'd0, 1'b1);
      send_item(it);
    end
    drain();

    $display("run covered %0d input transfers and %0d result transfers, %0d timeouts",
             transfers_sent, result_count, timeout_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: outstanding_transaction_tracker.f
src/ott_pkg.sv
src/ott_ctrl.sv
src/ott_dp.sv
src/outstanding_transaction_tracker.sv
tb/ott_result_checker.sv
tb/tb_outstanding_transaction_tracker.sv
